FILE: hw/rtl/bba_pkg.sv
package bba_pkg;

    typedef struct packed {
        logic        operation;
        logic [16:0] request_bytes;
        logic [15:0] free_offset;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_offset;
        logic [4:0]  block_order;
        logic [16:0] used_bytes;
    } out_word_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_HEADER = 1'b0;

    // free map rows hold 32 tree nodes each
    localparam int ROW_BITS = 32;
    localparam int BIT_W    = 5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_A_SCAN,
        S_A_CHECK,
        S_A_SPLIT_RD,
        S_A_SPLIT_WR,
        S_A_MAP,
        S_F_MAPCHK,
        S_F_BUD_RD,
        S_F_BUD_CHK,
        S_F_SET_RD,
        S_F_SET_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic       fail;
        logic [1:0] fail_code;
        logic       scan;
        logic       next_level;
        logic       take;
        logic       split_rd;
        logic       wr_set;
        logic       map_wr;
        logic       free_take;
        logic       bud_rd;
        logic       bud_take;
        logic       set_rd;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_free;
        logic bad_size;
        logic bad_align;
        logic row_hit;
        logic scan_hit;
        logic at_top;
        logic split_more;
        logic map_nz;
        logic tgt_free;
    } sts_t;

endpackage

FILE: hw/rtl/bba_ram.sv
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/bba_ctrl.sv
module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd,
    output logic          busy
);

    bba_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::S_CLEAR:
                if (sts.clear_done) state_next = bba_pkg::S_IDLE;
            bba_pkg::S_IDLE:
                if (start) state_next = bba_pkg::S_DECIDE;
            bba_pkg::S_DECIDE:
                if (sts.is_free)
                    state_next = sts.bad_align ? bba_pkg::S_DONE : bba_pkg::S_F_MAPCHK;
                else
                    state_next = sts.bad_size ? bba_pkg::S_DONE : bba_pkg::S_A_SCAN;
            bba_pkg::S_A_SCAN:
                if (sts.row_hit) state_next = bba_pkg::S_A_CHECK;
                else if (sts.at_top) state_next = bba_pkg::S_DONE;
            bba_pkg::S_A_CHECK:
                if (sts.scan_hit)
                    state_next = sts.split_more ? bba_pkg::S_A_SPLIT_RD : bba_pkg::S_A_MAP;
                else if (sts.at_top)
                    state_next = bba_pkg::S_DONE;
                else
                    state_next = bba_pkg::S_A_SCAN;
            bba_pkg::S_A_SPLIT_RD:
                state_next = bba_pkg::S_A_SPLIT_WR;
            bba_pkg::S_A_SPLIT_WR:
                state_next = sts.split_more ? bba_pkg::S_A_SPLIT_RD : bba_pkg::S_A_MAP;
            bba_pkg::S_A_MAP:
                state_next = bba_pkg::S_DONE;
            bba_pkg::S_F_MAPCHK:
                state_next = sts.map_nz ? bba_pkg::S_F_BUD_RD : bba_pkg::S_DONE;
            bba_pkg::S_F_BUD_RD:
                state_next = sts.at_top ? bba_pkg::S_F_SET_RD : bba_pkg::S_F_BUD_CHK;
            bba_pkg::S_F_BUD_CHK:
                state_next = sts.tgt_free ? bba_pkg::S_F_BUD_RD : bba_pkg::S_F_SET_RD;
            bba_pkg::S_F_SET_RD:
                state_next = bba_pkg::S_F_SET_WR;
            bba_pkg::S_F_SET_WR:
                state_next = bba_pkg::S_DONE;
            bba_pkg::S_DONE:
                state_next = bba_pkg::S_IDLE;
            default:
                state_next = bba_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            bba_pkg::S_CLEAR:
                cmd.clear = 1'b1;
            bba_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            bba_pkg::S_DECIDE:
                if (sts.is_free && sts.bad_align)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = bba_pkg::ST_BAD_FREE;
                end
                else if (!sts.is_free && sts.bad_size)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = bba_pkg::ST_BAD_SIZE;
                end
            bba_pkg::S_A_SCAN:
                if (sts.row_hit)
                    cmd.scan = 1'b1;
                else if (sts.at_top)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = bba_pkg::ST_NO_FREE;
                end
                else
                    cmd.next_level = 1'b1;
            bba_pkg::S_A_CHECK:
                if (sts.scan_hit)
                    cmd.take = 1'b1;
                else if (sts.at_top)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = bba_pkg::ST_NO_FREE;
                end
                else
                    cmd.next_level = 1'b1;
            bba_pkg::S_A_SPLIT_RD:
                cmd.split_rd = 1'b1;
            bba_pkg::S_A_SPLIT_WR:
                cmd.wr_set = 1'b1;
            bba_pkg::S_A_MAP:
                cmd.map_wr = 1'b1;
            bba_pkg::S_F_MAPCHK:
                if (sts.map_nz)
                    cmd.free_take = 1'b1;
                else
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = bba_pkg::ST_BAD_FREE;
                end
            bba_pkg::S_F_BUD_RD:
                cmd.bud_rd = !sts.at_top;
            bba_pkg::S_F_BUD_CHK:
                cmd.bud_take = sts.tgt_free;
            bba_pkg::S_F_SET_RD:
                cmd.set_rd = 1'b1;
            bba_pkg::S_F_SET_WR:
                cmd.wr_set = 1'b1;
            bba_pkg::S_DONE:
                cmd.emit = 1'b1;
            default:
                cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/bba_datapath.sv
module bba_datapath #(
    parameter int MIN_ORDER = 5,
    parameter int MAX_ORDER = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bba_pkg::cmd_t        cmd,
    input  bba_pkg::in_word_t    request,
    input  logic [7:0]           header_overhead,
    output bba_pkg::sts_t        sts,
    output bba_pkg::out_word_t   result,
    output logic                 done
);

    localparam int NW    = MAX_ORDER - MIN_ORDER + 1;
    localparam int UW    = MAX_ORDER - MIN_ORDER;
    localparam int RAW   = (NW > bba_pkg::BIT_W) ? NW - bba_pkg::BIT_W : 1;
    localparam int ROWS  = 2 ** RAW;
    localparam int UNITS = 2 ** UW;
    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam int AW    = MAX_ORDER;
    localparam int USW   = MAX_ORDER + 1;
    localparam int LW    = $clog2(NW + 1);
    localparam int CLR_N = (ROWS > UNITS) ? ROWS : UNITS;
    localparam int CW    = $clog2(CLR_N);
    localparam int RB    = bba_pkg::ROW_BITS;

    function automatic logic [NW-1:0] node_of(input logic [OW-1:0] o,
                                              input logic [AW-1:0] a);
        logic [31:0] n;
        n = (32'd1 << (MAX_ORDER - int'(o))) + ({{(32-AW){1'b0}}, a} >> o);
        return n[NW-1:0];
    endfunction

    function automatic logic [RAW-1:0] row_of(input logic [NW-1:0] n);
        logic [31:0] t;
        t = {{(32-NW){1'b0}}, n} >> bba_pkg::BIT_W;
        return t[RAW-1:0];
    endfunction

    function automatic logic [bba_pkg::BIT_W-1:0] bit_of(input logic [NW-1:0] n);
        logic [31:0] t;
        t = {{(32-NW){1'b0}}, n};
        return t[bba_pkg::BIT_W-1:0];
    endfunction

    logic                 op_reg, bad_size_reg, bad_align_reg;
    logic [OW-1:0]        o_reg, need_reg;
    logic [AW-1:0]        off_reg;
    logic [NW-1:0]        tgt_reg;
    logic [RAW-1:0]       scan_row_reg;
    logic [USW-1:0]       used_reg;
    logic [ROWS-1:0]      sum_reg;
    logic [CW-1:0]        clr_cnt_reg;
    bba_pkg::out_word_t   res_reg;
    logic                 done_reg;

    logic [RB-1:0]        fm_rdata, fm_wdata;
    logic [RAW-1:0]       fm_raddr, fm_waddr;
    logic                 fm_we;
    logic [LW-1:0]        om_rdata, om_wdata;
    logic [UW-1:0]        om_addr, om_waddr;
    logic                 om_we;

    // level scan and row search
    logic [31:0]          cnt, lo, hi, nb, sel_node;
    logic                 row_hit, scan_hit;
    logic [RAW-1:0]       hit_row;
    logic [NW-1:0]        found_node, next_tgt, wnode;
    logic [AW-1:0]        found_off;
    logic [RB-1:0]        wmask;

    // load-time sizing
    logic [31:0]          total, off32;
    logic [OW-1:0]        need_c;
    logic [31:0]          unit32, ord32, used32;

    always_comb
    begin
        total = 32'(request.request_bytes) + 32'(header_overhead);
        need_c = OW'(MAX_ORDER);
        for (int k = MAX_ORDER; k >= MIN_ORDER; k--)
        begin
            if (total <= (32'd1 << k)) need_c = OW'(k);
        end
        off32 = 32'(request.free_offset);
    end

    always_comb
    begin
        cnt     = 32'd1 << (MAX_ORDER - int'(o_reg));
        lo      = cnt >> bba_pkg::BIT_W;
        hi      = ((cnt << 1) - 32'd1) >> bba_pkg::BIT_W;
        row_hit = 1'b0;
        hit_row = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (sum_reg[i] && 32'(i) >= lo && 32'(i) <= hi)
            begin
                row_hit = 1'b1;
                hit_row = RAW'(i);
            end
        end
        scan_hit = 1'b0;
        sel_node = '0;
        for (int b = RB - 1; b >= 0; b--)
        begin
            nb = (32'(scan_row_reg) << bba_pkg::BIT_W) | 32'(b);
            if (fm_rdata[b] && nb >= cnt && nb < (cnt << 1))
            begin
                scan_hit = 1'b1;
                sel_node = nb;
            end
        end
        found_node = sel_node[NW-1:0];
        found_off  = AW'((sel_node - cnt) << o_reg);
    end

    always_comb
    begin
        priority if (cmd.split_rd)
            next_tgt = node_of(o_reg - OW'(1), off_reg + (AW'(1) << (o_reg - OW'(1))));
        else if (cmd.bud_rd)
            next_tgt = node_of(o_reg, off_reg ^ (AW'(1) << o_reg));
        else if (cmd.set_rd)
            next_tgt = node_of(o_reg, off_reg);
        else
            next_tgt = tgt_reg;
        fm_raddr = cmd.scan ? hit_row : row_of(next_tgt);

        wnode = cmd.take ? found_node : tgt_reg;
        wmask = RB'(1) << bit_of(wnode);
        if (cmd.clear)
        begin
            fm_we    = (32'(clr_cnt_reg) < 32'(ROWS));
            fm_waddr = clr_cnt_reg[RAW-1:0];
            fm_wdata = (clr_cnt_reg == '0) ? RB'(2) : '0;
        end
        else
        begin
            fm_we    = cmd.take | cmd.bud_take | cmd.wr_set;
            fm_waddr = row_of(wnode);
            fm_wdata = cmd.wr_set ? (fm_rdata | wmask) : (fm_rdata & ~wmask);
        end

        unit32   = {{(32-AW){1'b0}}, off_reg} >> MIN_ORDER;
        om_addr  = unit32[UW-1:0];
        om_we    = cmd.clear | cmd.map_wr | cmd.free_take;
        om_waddr = cmd.clear ? clr_cnt_reg[UW-1:0] : om_addr;
        om_wdata = cmd.map_wr ? LW'(int'(need_reg) - MIN_ORDER + 1) : '0;
        ord32    = 32'(om_rdata) + 32'(MIN_ORDER) - 32'd1;
        used32   = 32'(used_reg);
    end

    bba_ram #(.WIDTH(RB), .DEPTH(ROWS)) u_free_ram (
        .clk   (clk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    bba_ram #(.WIDTH(LW), .DEPTH(UNITS)) u_order_ram (
        .clk   (clk),
        .we    (om_we),
        .waddr (om_waddr),
        .wdata (om_wdata),
        .raddr (om_addr),
        .rdata (om_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            sum_reg     <= ROWS'(1);
            used_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (fm_we && !cmd.clear)
            begin
                sum_reg[fm_waddr] <= |fm_wdata;
            end
            if (cmd.map_wr)
            begin
                used_reg <= USW'(used32 + (32'd1 << need_reg));
            end
            if (cmd.free_take)
            begin
                used_reg <= USW'(used32 - (32'd1 << ord32));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= request.operation;
            bad_size_reg  <= (request.request_bytes == '0)
                             || (total > (32'd1 << MAX_ORDER));
            bad_align_reg <= ((off32 & ((32'd1 << MIN_ORDER) - 32'd1)) != '0)
                             || ((off32 >> MAX_ORDER) != '0);
            need_reg      <= need_c;
            o_reg         <= need_c;
            off_reg       <= AW'(off32);
        end
        if (cmd.scan)
        begin
            scan_row_reg <= hit_row;
        end
        if (cmd.next_level)
        begin
            o_reg <= o_reg + OW'(1);
        end
        if (cmd.take)
        begin
            off_reg <= found_off;
        end
        if (cmd.split_rd)
        begin
            o_reg <= o_reg - OW'(1);
        end
        if (cmd.split_rd || cmd.bud_rd || cmd.set_rd)
        begin
            tgt_reg <= next_tgt;
        end
        if (cmd.bud_take)
        begin
            off_reg <= off_reg & ~(AW'(1) << o_reg);
            o_reg   <= o_reg + OW'(1);
        end
        if (cmd.free_take)
        begin
            o_reg                <= OW'(ord32);
            res_reg.status       <= bba_pkg::ST_OK;
            res_reg.block_offset <= 16'(off_reg);
            res_reg.block_order  <= 5'(ord32);
            res_reg.used_bytes   <= 17'(used32 - (32'd1 << ord32));
        end
        if (cmd.map_wr)
        begin
            res_reg.status       <= bba_pkg::ST_OK;
            res_reg.block_offset <= 16'(off_reg);
            res_reg.block_order  <= 5'(need_reg);
            res_reg.used_bytes   <= 17'(used32 + (32'd1 << need_reg));
        end
        if (cmd.fail)
        begin
            res_reg.status       <= cmd.fail_code;
            res_reg.block_offset <= '0;
            res_reg.block_order  <= '0;
            res_reg.used_bytes   <= 17'(used32);
        end
    end

    always_comb
    begin
        sts.clear_done = (32'(clr_cnt_reg) == 32'(CLR_N - 1));
        sts.is_free    = (op_reg == bba_pkg::OP_FREE);
        sts.bad_size   = bad_size_reg;
        sts.bad_align  = bad_align_reg;
        sts.row_hit    = row_hit;
        sts.scan_hit   = scan_hit;
        sts.at_top     = (32'(o_reg) >= 32'(MAX_ORDER));
        sts.split_more = (o_reg > need_reg);
        sts.map_nz     = (om_rdata != '0);
        sts.tgt_free   = fm_rdata[bit_of(tgt_reg)];
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

FILE: hw/rtl/buddy_block_allocator.sv
// Buddy allocator: one command word in while busy is low, one result word out on done.
// Allocate: scans the levels upward from the needed order, then splits down; a bad size skips the scan.
// Free: merges upwards while the buddy is free; a bad free skips the merge; next word in the done cycle.
// After reset a clearing pass runs with busy high.
// Results are shown for one cycle on done; the receiver cannot stall.
module buddy_block_allocator #(
    parameter int MIN_ORDER = 5,
    parameter int MAX_ORDER = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bba_pkg::in_word_t   request,
    output logic                done,
    output bba_pkg::out_word_t  result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    bba_pkg::cmd_t cmd;
    bba_pkg::sts_t sts;
    logic [7:0]    header_reg;

    // Register file: only the header overhead, at byte address 0.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == bba_pkg::REG_HEADER)
        begin
            header_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bba_pkg::REG_HEADER)
        begin
            prdata = {24'd0, header_reg};
        end
    end

    // Sequencer: walks the order levels, one free-map row access per step.
    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: free-bit tree, per-unit order map, used total and result word.
    bba_datapath #(
        .MIN_ORDER (MIN_ORDER),
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .request         (request),
        .header_overhead (header_reg),
        .sts             (sts),
        .result          (result),
        .done            (done)
    );

endmodule

FILE: hw/rtl/bba_checker.sv
module bba_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input bba_pkg::out_word_t result
);

    // a result only follows work in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a command in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word repeated");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != bba_pkg::ST_OK) |->
        (result.block_offset == '0 && result.block_order == '0))
        else $error("failure word carries offset or order");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

FILE: sim/tb_buddy_block_allocator.sv
`timescale 1ns / 100ps

// Buddy allocator bench. A driver issues command words from a queue, a
// monitor checks every result word against a software copy of the tree.
module tb_buddy_block_allocator;

    localparam int MIN_ORD = 5;
    localparam int MAX_ORD = 16;
    localparam int UNIT_CNT = 1 << (MAX_ORD - MIN_ORD);
    localparam int NODE_CNT = 2 * UNIT_CNT;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] ADDR_HEADER = {bba_pkg::REG_HEADER, 2'b00};

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    bba_pkg::in_word_t request;
    logic done;
    bba_pkg::out_word_t result;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    buddy_block_allocator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow of the allocator: tree free bits, per-unit order tags, usage
    bit        tree_free [NODE_CNT];
    bit [3:0]  unit_tag [UNIT_CNT];
    bit [16:0] bytes_used;
    bit [7:0]  hdr_bytes;

    bba_pkg::in_word_t  cmd_queue [$];
    bba_pkg::out_word_t want_queue [$];
    int        mismatches;
    int        accepted;
    int        results_seen;
    int        idle_run;
    bit        no_idle;
    // live allocations, used to aim frees at real blocks
    bit [15:0] live_offs [$];

    function automatic int node_at(int ord, int off);
        return (1 << (MAX_ORD - ord)) + (off >> ord);
    endfunction

    function automatic bba_pkg::out_word_t predict_alloc(int req);
        bba_pkg::out_word_t r;
        int total, need, off, o;
        bit hit;
        total = req + int'(hdr_bytes);
        r = '0;
        if (req == 0 || total > (1 << MAX_ORD))
        begin
            r.status = bba_pkg::ST_BAD_SIZE;
            r.used_bytes = bytes_used;
            return r;
        end
        need = MIN_ORD;
        while ((1 << need) < total)
            need++;
        hit = 0;
        off = 0;
        for (o = need; o <= MAX_ORD && !hit; o++)
        begin
            for (int i = 0; i < (1 << (MAX_ORD - o)); i++)
            begin
                if (tree_free[(1 << (MAX_ORD - o)) + i])
                begin
                    tree_free[(1 << (MAX_ORD - o)) + i] = 0;
                    off = i << o;
                    hit = 1;
                    break;
                end
            end
            if (hit)
            begin
                // split down: each upper half goes free
                for (int s = o - 1; s >= need; s--)
                    tree_free[node_at(s, off + (1 << s))] = 1;
            end
        end
        if (!hit)
        begin
            r.status = bba_pkg::ST_NO_FREE;
            r.used_bytes = bytes_used;
            return r;
        end
        unit_tag[off >> MIN_ORD] = 4'(need - MIN_ORD + 1);
        bytes_used += 17'(1 << need);
        r.status = bba_pkg::ST_OK;
        r.block_offset = 16'(off);
        r.block_order = 5'(need);
        r.used_bytes = bytes_used;
        return r;
    endfunction

    function automatic bba_pkg::out_word_t predict_free(int off);
        bba_pkg::out_word_t r;
        int u, ord, o, a, bud;
        r = '0;
        u = off >> MIN_ORD;
        if ((off & ((1 << MIN_ORD) - 1)) != 0 || unit_tag[u] == 0)
        begin
            r.status = bba_pkg::ST_BAD_FREE;
            r.used_bytes = bytes_used;
            return r;
        end
        ord = int'(unit_tag[u]) - 1 + MIN_ORD;
        unit_tag[u] = 0;
        bytes_used -= 17'(1 << ord);
        o = ord;
        a = off;
        // merge upwards while the buddy is free at the same order
        while (o < MAX_ORD)
        begin
            bud = a ^ (1 << o);
            if (!tree_free[node_at(o, bud)])
                break;
            tree_free[node_at(o, bud)] = 0;
            a &= ~(1 << o);
            o++;
        end
        tree_free[node_at(o, a)] = 1;
        r.status = bba_pkg::ST_OK;
        r.block_offset = 16'(off);
        r.block_order = 5'(ord);
        r.used_bytes = bytes_used;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Driver: hold start until the word is taken, predict at acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (request.operation == bba_pkg::OP_ALLOC)
                    want_queue.push_back(predict_alloc(int'(request.request_bytes)));
                else
                    want_queue.push_back(predict_free(int'(request.free_offset)));
                accepted++;
                void'(cmd_queue.pop_front());
            end
            if (!(start && busy))
            begin
                if (cmd_queue.size() > 0 && (no_idle || $urandom_range(99) >= 14))
                begin
                    start <= 1'b1;
                    request <= cmd_queue[0];
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (want_queue.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                bba_pkg::out_word_t w;
                w = want_queue.pop_front();
                if (result.status != w.status)
                    report_mismatch("status", int'(result.status), int'(w.status));
                if (result.block_offset != w.block_offset)
                    report_mismatch("block_offset", int'(result.block_offset),
                                    int'(w.block_offset));
                if (result.block_order != w.block_order)
                    report_mismatch("block_order", int'(result.block_order),
                                    int'(w.block_order));
                if (result.used_bytes != w.used_bytes)
                    report_mismatch("used_bytes", int'(result.used_bytes),
                                    int'(w.used_bytes));
                if (w.status == bba_pkg::ST_OK && w.block_order != 0 &&
                    unit_tag[w.block_offset >> MIN_ORD] != 0)
                    live_offs.push_back(w.block_offset);
            end
        end
    end

    // Watchdog: count cycles with work pending and nothing accepted or returned
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n || cmd_queue.size() == 0 && want_queue.size() == 0)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run > STALL_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", idle_run);
            $display("buddy_block_allocator verification failed");
            $finish;
        end
    end

    task automatic write_header(input bit [7:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_HEADER;
        pwdata <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        hdr_bytes = val;
    endtask

    task automatic drain();
        while (cmd_queue.size() != 0 || want_queue.size() != 0 || start)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic bba_pkg::in_word_t alloc_word(int req);
        bba_pkg::in_word_t w;
        w = '0;
        w.operation = bba_pkg::OP_ALLOC;
        w.request_bytes = 17'(req);
        w.free_offset = 16'($urandom);
        return w;
    endfunction

    function automatic bba_pkg::in_word_t free_word(int off);
        bba_pkg::in_word_t w;
        w = '0;
        w.operation = bba_pkg::OP_FREE;
        w.free_offset = 16'(off);
        w.request_bytes = 17'($urandom);
        return w;
    endfunction

    // Pick a random request size, mostly small, sometimes huge or bad
    function automatic int pick_size();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(1, 1 << $urandom_range(5, 11));
        if (k < 85)
            return $urandom_range(1, 16384);
        if (k < 93)
            return $urandom_range(0, 131071);
        return 0;
    endfunction

    task automatic random_phase(input int n);
        int k, pick;
        for (int i = 0; i < n; i++)
        begin
            // keep the queue short so the live block list stays close to current before aiming frees
            while (cmd_queue.size() > 2)
                @(posedge clk);
            k = $urandom_range(99);
            if (k < 50)
                cmd_queue.push_back(alloc_word(pick_size()));
            else if (k < 88 && live_offs.size() != 0)
            begin
                pick = $urandom_range(live_offs.size() - 1);
                cmd_queue.push_back(free_word(int'(live_offs[pick])));
                live_offs.delete(pick);
            end
            else
                cmd_queue.push_back(free_word(int'($urandom_range(65535))));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        accepted = 0;
        results_seen = 0;
        idle_run = 0;
        no_idle = 0;
        hdr_bytes = 0;
        bytes_used = 0;
        foreach (tree_free[i]) tree_free[i] = 0;
        foreach (unit_tag[i]) unit_tag[i] = 0;
        tree_free[1] = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // wait out the clearing pass before touching registers
        @(posedge clk);
        while (busy)
            @(posedge clk);

        write_header(8'd0);
        // directed: bad sizes, whole pool, exhaustion, bad frees, merges
        cmd_queue.push_back(alloc_word(0));
        cmd_queue.push_back(alloc_word(65537));
        cmd_queue.push_back(alloc_word(131071));
        cmd_queue.push_back(alloc_word(65536));
        cmd_queue.push_back(alloc_word(1));
        cmd_queue.push_back(free_word(0));
        cmd_queue.push_back(free_word(0));
        cmd_queue.push_back(alloc_word(1));
        cmd_queue.push_back(alloc_word(32));
        cmd_queue.push_back(alloc_word(33));
        cmd_queue.push_back(free_word(33));
        cmd_queue.push_back(free_word(65535));
        cmd_queue.push_back(free_word(65504));
        cmd_queue.push_back(free_word(32));
        cmd_queue.push_back(free_word(0));
        cmd_queue.push_back(free_word(64));
        cmd_queue.push_back(alloc_word(32768));
        cmd_queue.push_back(alloc_word(32768));
        cmd_queue.push_back(alloc_word(1));
        cmd_queue.push_back(free_word(32768));
        cmd_queue.push_back(free_word(0));
        drain();
        live_offs.delete();

        write_header(8'd255);
        cmd_queue.push_back(alloc_word(65281));
        cmd_queue.push_back(alloc_word(65282));
        cmd_queue.push_back(free_word(0));
        random_phase(120);
        drain();

        write_header(8'($urandom_range(1, 254)));
        no_idle = 1;
        random_phase(120);
        drain();
        no_idle = 0;

        write_header(8'd16);
        random_phase(140);
        drain();

        $display("covered %0d words across four header settings (0, 255, random, 16)",
                 accepted);
        $display("%0d result words checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && want_queue.size() == 0)
            $display("buddy_block_allocator verification clean");
        else
            $display("buddy_block_allocator verification failed");
        $finish;
    end
endmodule
